// ----- design/kcl_pkg.sv -----
// Shared types and constants for the keypad code lock controller.
// No dependencies; every other design file but kcl_in_stage refers to this package by scoped names.
package kcl_pkg;

	// Default number of digits in the stored code.
	localparam int CODE_LENGTH_DEF = 4;

	// Operation codes of an input item.
	localparam logic [1:0] OP_KEYPAD   = 2'd0;
	localparam logic [1:0] OP_TERMINAL = 2'd1;
	localparam logic [1:0] OP_TOGGLE   = 2'd2;
	localparam logic [1:0] OP_CHANGE   = 2'd3;

	// Lock modes.
	localparam logic [1:0] MODE_KEYPAD   = 2'd0;
	localparam logic [1:0] MODE_TERMINAL = 2'd1;
	localparam logic [1:0] MODE_IDENTIFY = 2'd2;
	localparam logic [1:0] MODE_NEWCODE  = 2'd3;

	// Result event codes.
	localparam logic [3:0] EV_IGNORED   = 4'd0;
	localparam logic [3:0] EV_DIGIT     = 4'd1;
	localparam logic [3:0] EV_CLEARED   = 4'd2;
	localparam logic [3:0] EV_OPEN      = 4'd3;
	localparam logic [3:0] EV_WRONG     = 4'd4;
	localparam logic [3:0] EV_IDENT_OK  = 4'd5;
	localparam logic [3:0] EV_CHANGED   = 4'd6;
	localparam logic [3:0] EV_CANCELLED = 4'd7;
	localparam logic [3:0] EV_REENTER   = 4'd8;
	localparam logic [3:0] EV_SWITCHED  = 4'd9;

	// ASCII key codes with a meaning.
	localparam logic [7:0] KEY_DIGIT_LO = 8'h30;
	localparam logic [7:0] KEY_DIGIT_HI = 8'h39;
	localparam logic [7:0] KEY_HASH     = 8'h23;
	localparam logic [7:0] KEY_STAR     = 8'h2A;
	localparam logic [7:0] KEY_DASH     = 8'h2D;

	// One result item.
	typedef struct packed {
		logic [3:0] event_res;
		logic [2:0] position;
		logic [3:0] digit_value;
		logic [1:0] lock_mode;
	} result_t;

endpackage

// ----- design/kcl_in_stage.sv -----
// Input register of the keypad code lock controller.
// Does not refer to kcl_pkg; holds one item ahead of the core.
module kcl_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] key,
	input  logic       advance,
	output logic       valid_s1,
	output logic [1:0] op_s1,
	output logic [7:0] key_s1
);

	// The register can take a new item when empty or when its item moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the held item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the held item.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= op;
			key_s1 <= key;
		end
	end

endmodule

// ----- design/kcl_core.sv -----
// Lock state and per-item update logic of the keypad code lock controller.
// Depends on kcl_pkg for modes, events, key codes and the result struct.
module kcl_core #(
	parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  logic [1:0]          op_s1,
	input  logic [7:0]          key_s1,
	output kcl_pkg::result_t    res
);

	localparam int CW = $clog2(CODE_LENGTH + 2);
	localparam logic [CW-1:0] COUNT_FULL   = CW'(CODE_LENGTH + 1);
	localparam logic [CW-1:0] COUNT_ENOUGH = CW'(CODE_LENGTH);

	logic [1:0]    mode_q;
	logic [CW-1:0] count_q;
	logic [3:0]    entry_q [CODE_LENGTH];
	logic [3:0]    code_q  [CODE_LENGTH];

	logic [1:0]    mode_d;
	logic [CW-1:0] count_d;
	logic          take_en;
	logic          store_en;
	logic [3:0]    ev;
	logic [2:0]    pos;
	logic [3:0]    dval;
	logic          is_digit;
	logic          keypad_like;
	logic          enough;
	logic          full;
	logic          match;
	logic [7:0]    clear_key;
	logic [3:0]    digit;

	// Key decode and entry status.
	assign is_digit    = (key_s1 >= kcl_pkg::KEY_DIGIT_LO) && (key_s1 <= kcl_pkg::KEY_DIGIT_HI);
	assign digit       = key_s1[3:0];
	assign keypad_like = (mode_q == kcl_pkg::MODE_KEYPAD) || (mode_q == kcl_pkg::MODE_TERMINAL);
	assign enough      = count_q >= COUNT_ENOUGH;
	assign full        = count_q >= COUNT_FULL;
	assign clear_key   = (mode_q == kcl_pkg::MODE_TERMINAL) ? kcl_pkg::KEY_DASH : kcl_pkg::KEY_HASH;

	// Compare the held entry with the stored code, digit by digit.
	always_comb begin
		match = enough;
		for (int k = 0; k < CODE_LENGTH; k++) begin
			if (entry_q[k] != code_q[k]) begin
				match = 1'b0;
			end
		end
	end

	// Next state and result of the item in the input register.
	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		take_en  = 1'b0;
		store_en = 1'b0;
		ev       = kcl_pkg::EV_IGNORED;
		pos      = 3'd0;
		dval     = 4'd0;
		unique case (op_s1)
			kcl_pkg::OP_TOGGLE: begin
				if (keypad_like) begin
					mode_d  = (mode_q == kcl_pkg::MODE_KEYPAD) ? kcl_pkg::MODE_TERMINAL
					                                            : kcl_pkg::MODE_KEYPAD;
					count_d = '0;
					ev      = kcl_pkg::EV_SWITCHED;
				end
			end
			kcl_pkg::OP_CHANGE: begin
				if (keypad_like) begin
					mode_d  = kcl_pkg::MODE_IDENTIFY;
					count_d = '0;
					ev      = kcl_pkg::EV_SWITCHED;
				end else if (mode_q == kcl_pkg::MODE_IDENTIFY) begin
					mode_d  = kcl_pkg::MODE_KEYPAD;
					count_d = '0;
					ev      = kcl_pkg::EV_CANCELLED;
				end
			end
			default: begin
				if ((op_s1 == kcl_pkg::OP_TERMINAL) != (mode_q == kcl_pkg::MODE_TERMINAL)) begin
					// A key from the source that is not active is ignored.
					ev = kcl_pkg::EV_IGNORED;
				end else if (mode_q == kcl_pkg::MODE_NEWCODE) begin
					if (is_digit) begin
						if (full) begin
							count_d = '0;
							ev      = kcl_pkg::EV_REENTER;
						end else begin
							take_en = 1'b1;
							count_d = count_q + 1'b1;
							pos     = 3'(count_q);
							dval    = digit;
							ev      = kcl_pkg::EV_DIGIT;
						end
					end else if (key_s1 == kcl_pkg::KEY_STAR) begin
						store_en = enough;
						ev       = enough ? kcl_pkg::EV_CHANGED : kcl_pkg::EV_CANCELLED;
						mode_d   = kcl_pkg::MODE_KEYPAD;
						count_d  = '0;
					end else if (key_s1 == kcl_pkg::KEY_HASH) begin
						mode_d  = kcl_pkg::MODE_KEYPAD;
						count_d = '0;
						ev      = kcl_pkg::EV_CANCELLED;
					end
				end else begin
					if (is_digit) begin
						if (full) begin
							count_d = '0;
							ev      = kcl_pkg::EV_CLEARED;
						end else begin
							take_en = 1'b1;
							count_d = count_q + 1'b1;
							pos     = 3'(count_q);
							ev      = kcl_pkg::EV_DIGIT;
						end
					end else if (key_s1 == clear_key) begin
						count_d = '0;
						ev      = kcl_pkg::EV_CLEARED;
					end else if (key_s1 == kcl_pkg::KEY_STAR) begin
						count_d = '0;
						if (mode_q == kcl_pkg::MODE_IDENTIFY) begin
							mode_d = match ? kcl_pkg::MODE_NEWCODE : kcl_pkg::MODE_KEYPAD;
							ev     = match ? kcl_pkg::EV_IDENT_OK : kcl_pkg::EV_WRONG;
						end else begin
							ev = match ? kcl_pkg::EV_OPEN : kcl_pkg::EV_WRONG;
						end
					end
				end
			end
		endcase
	end

	assign res.event_res   = ev;
	assign res.position    = pos;
	assign res.digit_value = dval;
	assign res.lock_mode   = mode_d;

	// Mode, entry count and stored code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= kcl_pkg::MODE_KEYPAD;
			count_q <= '0;
			for (int k = 0; k < CODE_LENGTH; k++) begin
				code_q[k] <= 4'd0;
			end
		end else if (commit) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			if (store_en) begin
				for (int k = 0; k < CODE_LENGTH; k++) begin
					code_q[k] <= entry_q[k];
				end
			end
		end
	end

	// Entry digits; a digit lands at the slot given by the count.
	// Digits past the count never affect a result, so the entry needs no clearing.
	always_ff @(posedge clk) begin
		for (int k = 0; k < CODE_LENGTH; k++) begin
			if (commit && take_en && (count_q == CW'(k))) begin
				entry_q[k] <= digit;
			end
		end
	end

	// The count never passes one beyond the code length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("entry count beyond its limit");

	// Only a taken digit reports a position.
	a_pos_digit: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (res.event_res != kcl_pkg::EV_DIGIT) |-> res.position == 3'd0)
		else $error("position reported without a digit");

	// A good identity leads into new code entry with an empty entry.
	a_ident_ok: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (res.event_res == kcl_pkg::EV_IDENT_OK)
		|=> (mode_q == kcl_pkg::MODE_NEWCODE) && (count_q == '0))
		else $error("identity accepted without entering new code mode");

	// A stored code change returns to keypad mode.
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (res.event_res == kcl_pkg::EV_CHANGED)
		|=> (mode_q == kcl_pkg::MODE_KEYPAD) && (count_q == '0))
		else $error("code change did not return to keypad mode");

endmodule

// ----- design/kcl_out_stage.sv -----
// Result register of the keypad code lock controller.
// Depends on kcl_pkg for the result struct.
module kcl_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  kcl_pkg::result_t res,
	output logic             out_valid,
	input  logic             out_ready,
	output kcl_pkg::result_t res_q
);

	// Valid flag: set on load, cleared once the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- design/keypad_code_lock_controller.sv -----
// Top level of the keypad code lock controller: input register, lock core, result register.
// Depends on kcl_pkg, kcl_in_stage, kcl_core and kcl_out_stage.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   op[1:0], key[7:0]
//   output   out_valid / out_ready event_res[3:0], position[2:0], digit_value[3:0], lock_mode[1:0]
//
// The lock update works on the item in the input register and loads the result register
// as that item moves on; the state update and the result load share that edge.
// One item is accepted per cycle unless a result stalls; the core's state update sets that rate.
// Reset clears the mode to keypad, empties the entry and sets the stored code to all zeros.
// A stalled result holds in the result register; the input register still takes one more item.
module keypad_code_lock_controller #(
	parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] key,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] event_res,
	output logic [2:0] position,
	output logic [3:0] digit_value,
	output logic [1:0] lock_mode
);

	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [7:0]       key_s1;
	logic             advance;
	kcl_pkg::result_t res;
	kcl_pkg::result_t res_q;

	// The held item moves on when the result register is free or being emptied.
	assign advance = valid_s1 && (!out_valid || out_ready);

	kcl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.key      (key),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.key_s1   (key_s1)
	);

	kcl_core #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.op_s1  (op_s1),
		.key_s1 (key_s1),
		.res    (res)
	);

	kcl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign event_res   = res_q.event_res;
	assign position    = res_q.position;
	assign digit_value = res_q.digit_value;
	assign lock_mode   = res_q.lock_mode;

endmodule

// ----- tb/kcl_lock_checker.sv -----
`timescale 1ns / 100ps
// Checker for the keypad code lock controller: watches both channels, predicts every result item.
// Depends on kcl_pkg for operation, mode, event and key codes and for the result type.
module kcl_lock_checker #(
	parameter int CODE_DIGITS = kcl_pkg::CODE_LENGTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [7:0]                 key,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [3:0]                 event_res,
	input  logic [2:0]                 position,
	input  logic [3:0]                 digit_value,
	input  logic [1:0]                 lock_mode,
	output int                         fail_count,
	output int                         pending_results,
	output int                         results_checked,
	output int                         opens_seen,
	output int                         changes_seen,
	output logic [1:0]                 mode_now,
	output logic [4*CODE_DIGITS-1:0]   code_now
);

	// Predicted lock state, updated as each input item is accepted.
	logic [1:0]       pred_mode;
	logic [3:0]       entry_q [CODE_DIGITS];
	int               entry_cnt;
	logic [3:0]       code_q [CODE_DIGITS];
	kcl_pkg::result_t lock_results_due [$];

	// The stimulus steers its sequences by the predicted mode and code.
	assign mode_now = pred_mode;
	always_comb begin
		for (int i = 0; i < CODE_DIGITS; i++)
			code_now[4*i +: 4] = code_q[i];
	end

	task automatic empty_entry();
		for (int i = 0; i < CODE_DIGITS; i++)
			entry_q[i] = '0;
		entry_cnt = 0;
	endtask

	// Works out the result of one item and moves the predicted state on.
	task automatic predict_lock(input logic [1:0] o, input logic [7:0] k,
		output kcl_pkg::result_t r);
		logic       is_digit;
		logic [3:0] d;
		logic [7:0] clr_key;
		logic       ok;
		r = '0;
		r.event_res = kcl_pkg::EV_IGNORED;
		is_digit = (k >= kcl_pkg::KEY_DIGIT_LO) && (k <= kcl_pkg::KEY_DIGIT_HI);
		// Digit keys start at 0x30, so the low nibble is the digit.
		d = is_digit ? k[3:0] : 4'd0;
		case (o)
			kcl_pkg::OP_TOGGLE: begin
				if (pred_mode == kcl_pkg::MODE_KEYPAD || pred_mode == kcl_pkg::MODE_TERMINAL) begin
					pred_mode = (pred_mode == kcl_pkg::MODE_KEYPAD) ? kcl_pkg::MODE_TERMINAL
					                                                : kcl_pkg::MODE_KEYPAD;
					empty_entry();
					r.event_res = kcl_pkg::EV_SWITCHED;
				end
			end
			kcl_pkg::OP_CHANGE: begin
				if (pred_mode == kcl_pkg::MODE_KEYPAD || pred_mode == kcl_pkg::MODE_TERMINAL) begin
					pred_mode = kcl_pkg::MODE_IDENTIFY;
					empty_entry();
					r.event_res = kcl_pkg::EV_SWITCHED;
				end else if (pred_mode == kcl_pkg::MODE_IDENTIFY) begin
					pred_mode = kcl_pkg::MODE_KEYPAD;
					empty_entry();
					r.event_res = kcl_pkg::EV_CANCELLED;
				end
			end
			default: begin
				if ((o == kcl_pkg::OP_TERMINAL) != (pred_mode == kcl_pkg::MODE_TERMINAL)) begin
					// A key from the source that is not selected is ignored.
					r.event_res = kcl_pkg::EV_IGNORED;
				end else if (pred_mode == kcl_pkg::MODE_NEWCODE) begin
					if (is_digit) begin
						if (entry_cnt >= CODE_DIGITS + 1) begin
							empty_entry();
							r.event_res = kcl_pkg::EV_REENTER;
						end else begin
							r.position = entry_cnt[2:0];
							if (entry_cnt < CODE_DIGITS)
								entry_q[entry_cnt] = d;
							entry_cnt++;
							r.digit_value = d;
							r.event_res = kcl_pkg::EV_DIGIT;
						end
					end else if (k == kcl_pkg::KEY_STAR) begin
						if (entry_cnt >= CODE_DIGITS) begin
							code_q = entry_q;
							r.event_res = kcl_pkg::EV_CHANGED;
						end else begin
							r.event_res = kcl_pkg::EV_CANCELLED;
						end
						pred_mode = kcl_pkg::MODE_KEYPAD;
						empty_entry();
					end else if (k == kcl_pkg::KEY_HASH) begin
						pred_mode = kcl_pkg::MODE_KEYPAD;
						empty_entry();
						r.event_res = kcl_pkg::EV_CANCELLED;
					end
				end else begin
					clr_key = (pred_mode == kcl_pkg::MODE_TERMINAL) ? kcl_pkg::KEY_DASH
					                                                : kcl_pkg::KEY_HASH;
					if (is_digit) begin
						if (entry_cnt >= CODE_DIGITS + 1) begin
							empty_entry();
							r.event_res = kcl_pkg::EV_CLEARED;
						end else begin
							r.position = entry_cnt[2:0];
							if (entry_cnt < CODE_DIGITS)
								entry_q[entry_cnt] = d;
							entry_cnt++;
							r.event_res = kcl_pkg::EV_DIGIT;
						end
					end else if (k == clr_key) begin
						empty_entry();
						r.event_res = kcl_pkg::EV_CLEARED;
					end else if (k == kcl_pkg::KEY_STAR) begin
						ok = (entry_cnt >= CODE_DIGITS);
						for (int i = 0; i < CODE_DIGITS; i++)
							if (entry_q[i] != code_q[i])
								ok = 1'b0;
						empty_entry();
						if (pred_mode == kcl_pkg::MODE_IDENTIFY) begin
							pred_mode = ok ? kcl_pkg::MODE_NEWCODE : kcl_pkg::MODE_KEYPAD;
							r.event_res = ok ? kcl_pkg::EV_IDENT_OK : kcl_pkg::EV_WRONG;
						end else begin
							r.event_res = ok ? kcl_pkg::EV_OPEN : kcl_pkg::EV_WRONG;
						end
					end
				end
			end
		endcase
		r.lock_mode = pred_mode;
	endtask

	// Predict on accepted input items, compare accepted result items with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		kcl_pkg::result_t want;
		kcl_pkg::result_t got;
		logic             bad;
		if (!arst_n) begin
			pred_mode = kcl_pkg::MODE_KEYPAD;
			empty_entry();
			for (int i = 0; i < CODE_DIGITS; i++)
				code_q[i] = '0;
			lock_results_due.delete();
			fail_count = 0;
			pending_results = 0;
			results_checked = 0;
			opens_seen = 0;
			changes_seen = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_lock(op, key, want);
				lock_results_due.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = {event_res, position, digit_value, lock_mode};
				if (lock_results_due.size() == 0) begin
					$display("%0t: result item with none expected: event_res %0d position %0d",
						$time, got.event_res, got.position);
					$display("%0t: digit_value %0d lock_mode %0d",
						$time, got.digit_value, got.lock_mode);
					fail_count++;
				end else begin
					want = lock_results_due.pop_front();
					bad = 1'b0;
					if (got.event_res !== want.event_res) begin
						$display("%0t: event_res expected %0d, actual %0d",
							$time, want.event_res, got.event_res);
						bad = 1'b1;
					end
					if (got.position !== want.position) begin
						$display("%0t: position expected %0d, actual %0d",
							$time, want.position, got.position);
						bad = 1'b1;
					end
					if (got.digit_value !== want.digit_value) begin
						$display("%0t: digit_value expected %0d, actual %0d",
							$time, want.digit_value, got.digit_value);
						bad = 1'b1;
					end
					if (got.lock_mode !== want.lock_mode) begin
						$display("%0t: lock_mode expected %0d, actual %0d",
							$time, want.lock_mode, got.lock_mode);
						bad = 1'b1;
					end
					if (bad)
						fail_count++;
					results_checked++;
					if (want.event_res == kcl_pkg::EV_OPEN)
						opens_seen++;
					if (want.event_res == kcl_pkg::EV_CHANGED)
						changes_seen++;
				end
			end
			pending_results = lock_results_due.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the keypad code lock testbench: clock, reset, key stimulus, receiver stalls and verdict.
// Depends on kcl_pkg, the keypad_code_lock_controller block and the kcl_lock_checker module.
module testbench;

	localparam int CODE_DIGITS = kcl_pkg::CODE_LENGTH_DEF;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] op;
	logic [7:0] key;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] event_res;
	logic [2:0] position;
	logic [3:0] digit_value;
	logic [1:0] lock_mode;

	int                       fail_count;
	int                       pending_results;
	int                       results_checked;
	int                       opens_seen;
	int                       changes_seen;
	logic [1:0]               mode_now;
	logic [4*CODE_DIGITS-1:0] code_now;

	int items_sent = 0;
	int send_gap_pct = 30;
	int recv_stall_pct = 47;

	keypad_code_lock_controller dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_res  (event_res),
		.position   (position),
		.digit_value(digit_value),
		.lock_mode  (lock_mode)
	);

	kcl_lock_checker #(.CODE_DIGITS(CODE_DIGITS)) lock_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.key            (key),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_res      (event_res),
		.position       (position),
		.digit_value    (digit_value),
		.lock_mode      (lock_mode),
		.fail_count     (fail_count),
		.pending_results(pending_results),
		.results_checked(results_checked),
		.opens_seen     (opens_seen),
		.changes_seen   (changes_seen),
		.mode_now       (mode_now),
		.code_now       (code_now)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random in the proportion of the current phase.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Sender gaps and receiver stalls: one way, the other way round, then none at all.
	task automatic set_phase();
		if (items_sent < 450) begin
			send_gap_pct = 30;
			recv_stall_pct = 47;
		end else if (items_sent < 850) begin
			send_gap_pct = 47;
			recv_stall_pct = 30;
		end else begin
			send_gap_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	// Offers one item at a falling edge and holds it until it is accepted.
	task automatic send_item(input logic [1:0] o, input logic [7:0] k);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		key <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_keys(input logic [1:0] o, input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(o, s[i]);
	endtask

	function automatic logic [7:0] any_digit();
		return {4'h3, 4'($urandom_range(0, 9))};
	endfunction

	// Mostly four digits, sometimes a short, long or overrunning entry.
	function automatic int entry_length();
		int r;
		r = $urandom_range(0, 9);
		return (r == 0) ? 3 : (r == 1) ? 5 : (r == 2) ? 6 : 4;
	endfunction

	// Enters a code, right or wrong, on the given source, at times clears it, and presses '*'.
	task automatic try_code(input logic [1:0] src, input bit right);
		int n;
		n = entry_length();
		for (int i = 0; i < n; i++) begin
			if (right && i < CODE_DIGITS)
				send_item(src, {4'h3, code_now[4*i +: 4]});
			else
				send_item(src, any_digit());
		end
		if ($urandom_range(0, 9) == 0)
			send_item(src, (src == kcl_pkg::OP_TERMINAL) ? kcl_pkg::KEY_DASH : kcl_pkg::KEY_HASH);
		send_item(src, kcl_pkg::KEY_STAR);
	endtask

	// Types a new code, with an occasional ignored item, then stores or cancels it.
	task automatic enter_new_code();
		int n;
		n = entry_length();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item($urandom_range(0, 1) ? kcl_pkg::OP_TOGGLE : kcl_pkg::OP_CHANGE,
					8'($urandom()));
			send_item(kcl_pkg::OP_KEYPAD, any_digit());
		end
		send_item(kcl_pkg::OP_KEYPAD,
			($urandom_range(0, 99) < 85) ? kcl_pkg::KEY_STAR : kcl_pkg::KEY_HASH);
	endtask

	// Change request, identification on the keypad, and the new code where it is allowed.
	task automatic change_code();
		send_item(kcl_pkg::OP_CHANGE, 8'($urandom()));
		if (mode_now == kcl_pkg::MODE_IDENTIFY) begin
			if ($urandom_range(0, 9) == 0)
				send_item(kcl_pkg::OP_CHANGE, 8'($urandom()));
			else
				try_code(kcl_pkg::OP_KEYPAD, $urandom_range(0, 99) < 80);
		end
		if (mode_now == kcl_pkg::MODE_NEWCODE)
			enter_new_code();
	endtask

	initial begin
		logic [1:0] src;
		int         pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = kcl_pkg::OP_KEYPAD;
		key = 8'h00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_phase();

		// Directed items: short entry, the reset code, wrong source, stray key, overrun,
		// terminal clear, change request cancel, identify and a new code.
		send_keys(kcl_pkg::OP_KEYPAD, "*");
		send_keys(kcl_pkg::OP_KEYPAD, "0000*");
		send_item(kcl_pkg::OP_TERMINAL, "5");
		send_item(kcl_pkg::OP_KEYPAD, 8'hFF);
		send_keys(kcl_pkg::OP_KEYPAD, "123456");
		send_item(kcl_pkg::OP_TOGGLE, 8'h00);
		send_keys(kcl_pkg::OP_TERMINAL, "#-");
		send_item(kcl_pkg::OP_CHANGE, 8'h00);
		send_item(kcl_pkg::OP_CHANGE, 8'h00);
		send_item(kcl_pkg::OP_CHANGE, 8'hFF);
		send_keys(kcl_pkg::OP_KEYPAD, "0000*");
		send_item(kcl_pkg::OP_TOGGLE, 8'h00);
		send_keys(kcl_pkg::OP_KEYPAD, "4321*");

		// Random part: mostly well-formed sequences steered by the predicted mode and code.
		while (items_sent < 1230) begin
			set_phase();
			src = (mode_now == kcl_pkg::MODE_TERMINAL) ? kcl_pkg::OP_TERMINAL : kcl_pkg::OP_KEYPAD;
			pick = $urandom_range(0, 99);
			if (mode_now == kcl_pkg::MODE_IDENTIFY)
				try_code(kcl_pkg::OP_KEYPAD, $urandom_range(0, 99) < 80);
			else if (mode_now == kcl_pkg::MODE_NEWCODE)
				enter_new_code();
			else if (pick < 35)
				try_code(src, $urandom_range(0, 99) < 70);
			else if (pick < 60)
				change_code();
			else if (pick < 70)
				send_item(kcl_pkg::OP_TOGGLE, 8'($urandom()));
			else if (pick < 78) begin
				repeat ($urandom_range(6, 8))
					send_item(src, any_digit());
				send_item(src, kcl_pkg::KEY_STAR);
			end else begin
				repeat ($urandom_range(1, 3))
					send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
		in_valid <= 1'b0;

		// Drain every expected result, then let the pipeline settle.
		while (pending_results != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d key and event items; checked %0d results,",
			items_sent, results_checked);
		$display("%0d openings, %0d code changes, with sender gaps and receiver stalls %s",
			opens_seen, changes_seen, "in both proportions and then without any.");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
